### rtl/mlr_pkg.sv
package mlr_pkg;

   localparam int COORD_BITS = 11;
   localparam int DEC_BITS = COORD_BITS + 4;
   localparam int COLOR_BITS = 24;
   localparam int REQ_FIELD_BITS = 4 * COORD_BITS + COLOR_BITS;
   localparam int REQ_DATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic signed [COORD_BITS:0] delta_type;
   typedef logic signed [DEC_BITS-1:0] dec_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef enum logic [1:0] {
      OCT_SHALLOW_UP   = 2'd0,
      OCT_STEEP_UP     = 2'd1,
      OCT_SHALLOW_DOWN = 2'd2,
      OCT_STEEP_DOWN   = 2'd3
   } octant_type;

   typedef struct packed {
      coord_type  cur_x;
      coord_type  cur_y;
      coord_type  major_end;
      dec_type    decision;
      dec_type    inc_keep;
      dec_type    inc_move;
      octant_type octant;
   } line_state_type;

   function automatic logic is_shallow(input octant_type oct);
      return (oct == OCT_SHALLOW_UP) || (oct == OCT_SHALLOW_DOWN);
   endfunction

   function automatic logic at_end(input line_state_type st);
      coord_type major;
      major = is_shallow(st.octant) ? st.cur_x : st.cur_y;
      return major == st.major_end;
   endfunction

   function automatic dec_type widen(input delta_type d);
      return {{(DEC_BITS - COORD_BITS - 1){d[COORD_BITS]}}, d};
   endfunction

endpackage

### rtl/mlr_setup.sv
module mlr_setup
   import mlr_pkg::*;
(
   input  coord_type      x_start,
   input  coord_type      y_start,
   input  coord_type      x_end,
   input  coord_type      y_end,
   output line_state_type init_state
);

   delta_type  dx0, dy0, dx1, dy1;
   coord_type  adx, ady;
   coord_type  ax, ay, bx, by;
   logic       same_sign, dx_nz, shallow, swap;
   octant_type oct;
   dec_type    dxe, dye;

   always_comb begin
      dx0 = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
      dy0 = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
      adx = dx0[COORD_BITS] ? coord_type'(-dx0) : dx0[COORD_BITS-1:0];
      ady = dy0[COORD_BITS] ? coord_type'(-dy0) : dy0[COORD_BITS-1:0];
      dx_nz = (dx0 != '0);
      same_sign = (dx0 > 0 && dy0 > 0) || (dx0 < 0 && dy0 < 0);
      shallow = dx_nz && (ady <= adx);

      if (shallow && ((dy0 == '0) || same_sign)) begin
         oct = OCT_SHALLOW_UP;
      end else if ((ady > adx) && (dx_nz ? same_sign : (dy0 > 0))) begin
         oct = OCT_STEEP_UP;
      end else if (shallow) begin
         oct = OCT_SHALLOW_DOWN;
      end else begin
         oct = OCT_STEEP_DOWN;
      end

      swap = is_shallow(oct) ? (x_start > x_end) : (y_start > y_end);
      ax = swap ? x_end : x_start;
      ay = swap ? y_end : y_start;
      bx = swap ? x_start : x_end;
      by = swap ? y_start : y_end;
      dx1 = $signed({1'b0, bx}) - $signed({1'b0, ax});
      dy1 = $signed({1'b0, by}) - $signed({1'b0, ay});
      dxe = widen(dx1);
      dye = widen(dy1);

      init_state.cur_x = ax;
      init_state.cur_y = ay;
      init_state.octant = oct;
      case (oct)
         OCT_SHALLOW_UP: begin
            init_state.decision = dxe - dye - dye;
            init_state.inc_keep = -(dye + dye);
            init_state.inc_move = dxe + dxe - dye - dye;
            init_state.major_end = bx;
         end
         OCT_STEEP_UP: begin
            init_state.decision = dxe + dxe - dye;
            init_state.inc_keep = dxe + dxe;
            init_state.inc_move = dxe + dxe - dye - dye;
            init_state.major_end = by;
         end
         OCT_SHALLOW_DOWN: begin
            init_state.decision = -dxe - dye - dye;
            init_state.inc_keep = -(dye + dye);
            init_state.inc_move = -(dxe + dxe) - dye - dye;
            init_state.major_end = bx;
         end
         default: begin
            init_state.decision = dxe + dxe + dye;
            init_state.inc_keep = dxe + dxe;
            init_state.inc_move = dxe + dxe + dye + dye;
            init_state.major_end = by;
         end
      endcase
   end

endmodule

### rtl/mlr_step.sv
module mlr_step
   import mlr_pkg::*;
(
   input  line_state_type cur_state,
   output line_state_type next_state
);

   logic move;

   always_comb begin
      next_state = cur_state;
      case (cur_state.octant)
         OCT_SHALLOW_UP: begin
            move = (cur_state.decision <= 0);
            next_state.cur_x = cur_state.cur_x + 1'b1;
            if (move) begin
               next_state.cur_y = cur_state.cur_y + 1'b1;
            end
         end
         OCT_STEEP_UP: begin
            move = (cur_state.decision >= 0);
            next_state.cur_y = cur_state.cur_y + 1'b1;
            if (move) begin
               next_state.cur_x = cur_state.cur_x + 1'b1;
            end
         end
         OCT_SHALLOW_DOWN: begin
            move = (cur_state.decision >= 0);
            next_state.cur_x = cur_state.cur_x + 1'b1;
            if (move) begin
               next_state.cur_y = cur_state.cur_y - 1'b1;
            end
         end
         default: begin
            move = (cur_state.decision <= 0);
            next_state.cur_y = cur_state.cur_y + 1'b1;
            if (move) begin
               next_state.cur_x = cur_state.cur_x - 1'b1;
            end
         end
      endcase
      next_state.decision = cur_state.decision +
                            (move ? cur_state.inc_move : cur_state.inc_keep);
   end

endmodule

### rtl/midpoint_line_rasterizer.sv
// Midpoint line rasterizer, all octants, one pixel per item.
// The request channel carries start and step items. A start item (tuser low)
// loads both endpoints and a color and produces the first pixel. A step item
// (tuser high) produces the next pixel of the line in progress; a step with no
// line in progress is consumed and produces nothing. A start during a line
// drops the old line.
// The response channel carries one pixel per producing item, with tlast set
// on the far endpoint, after which steps are ignored until the next start.
// An accepted item is held in the input register, then the setup or step logic
// writes the line state and the output register together. Throughput is one
// item per clock while the receiver does not stall, since the decision update
// that feeds the line state back on itself is combinational.
// A stalled receiver holds the output register; one more item waits in the
// input register, and req_tready falls only when both are full.
// Synchronous reset empties both registers and leaves no line in progress.
module midpoint_line_rasterizer
   import mlr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // x_start, y_start, x_end, y_end, color, zero fill
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // kind
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // pixel_x, pixel_y, pixel_color, zero fill
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tlast
);

   logic                     in_valid_ff, in_valid_in;
   logic                     in_kind_ff;
   coord_type                in_xa_ff, in_ya_ff, in_xb_ff, in_yb_ff;
   color_type                in_color_ff;
   line_state_type           state_ff, state_in;
   logic                     active_ff, active_in;
   color_type                color_ff, color_in;
   logic                     out_valid_ff, out_valid_in;
   logic [RSP_DATA_BITS-1:0] out_data_ff, out_data_in;
   logic                     out_last_ff, out_last_in;

   line_state_type init_state, stepped_state, new_state;
   logic           req_fire, has_result, out_free, in_consume, fire, new_last;

   mlr_setup u_setup (
      .x_start    (in_xa_ff),
      .y_start    (in_ya_ff),
      .x_end      (in_xb_ff),
      .y_end      (in_yb_ff),
      .init_state (init_state)
   );

   mlr_step u_step (
      .cur_state  (state_ff),
      .next_state (stepped_state)
   );

   always_comb begin
      has_result = in_valid_ff && ((in_kind_ff == KIND_START) || active_ff);
      out_free = !out_valid_ff || rsp_tready;
      in_consume = in_valid_ff && (!has_result || out_free);
      fire = has_result && out_free;
      req_tready = !in_valid_ff || in_consume;
      req_fire = req_tvalid && req_tready;

      new_state = (in_kind_ff == KIND_START) ? init_state : stepped_state;
      new_last = at_end(new_state);

      in_valid_in = req_fire ? 1'b1 : (in_consume ? 1'b0 : in_valid_ff);
      state_in = fire ? new_state : state_ff;
      active_in = fire ? !new_last : active_ff;
      color_in = (fire && (in_kind_ff == KIND_START)) ? in_color_ff : color_ff;
      out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_data_in = fire
                  ? RSP_DATA_BITS'({color_in, new_state.cur_y, new_state.cur_x})
                  : out_data_ff;
      out_last_in = fire ? new_last : out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         active_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= '0;
         color_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         active_ff <= active_in;
         out_valid_ff <= out_valid_in;
         state_ff <= state_in;
         color_ff <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff <= req_tuser;
         in_xa_ff <= req_tdata[COORD_BITS-1:0];
         in_ya_ff <= req_tdata[2*COORD_BITS-1:COORD_BITS];
         in_xb_ff <= req_tdata[3*COORD_BITS-1:2*COORD_BITS];
         in_yb_ff <= req_tdata[4*COORD_BITS-1:3*COORD_BITS];
         in_color_ff <= req_tdata[REQ_FIELD_BITS-1:4*COORD_BITS];
      end
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_last_ff;

endmodule

### tb/midpoint_line_rasterizer_tb.sv
`timescale 1ns / 100ps

module midpoint_line_rasterizer_tb;
   import mlr_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_AT = 300;
   localparam int HOLD_LEN = 150;
   localparam int LINE_ITEMS = 450;
   localparam int COORD_MAX = (1 << COORD_BITS) - 1;

   typedef struct {
      logic      kind;
      coord_type xs;
      coord_type ys;
      coord_type xe;
      coord_type ye;
      color_type col;
      bit        drain;
   } cmd_type;

   typedef struct {
      coord_type px;
      coord_type py;
      color_type col;
      logic      last;
   } pixel_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     req_tuser = KIND_START;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;

   cmd_type   cmd_q[$];
   pixel_type pixel_q[$];
   bit        drained_q = 1'b1;
   int        err_count = 0;
   int        cycle_count = 0;
   int        send_gap = 0;
   int        tx_calm = 0;
   int        rx_calm = 0;
   int        rx_stall = 0;
   int        rx_cycle = 0;

   int         ln_x = 0;
   int         ln_y = 0;
   int         ln_end = 0;
   int         ln_dec = 0;
   int         ln_keep = 0;
   int         ln_move = 0;
   octant_type ln_oct = OCT_SHALLOW_UP;
   bit         line_on = 1'b0;
   color_type  ln_color = '0;

   midpoint_line_rasterizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int idle_len(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic coord_type near(input coord_type c, input int span);
      int off;
      int v;
      off = $urandom_range(0, span);
      v = $urandom_range(0, 1) ? int'(c) + off : int'(c) - off;
      if (v < 0 || v > COORD_MAX) v = 2 * int'(c) - v;
      return coord_type'(v);
   endfunction

   task automatic next_pixel(input logic kind, input coord_type xs, input coord_type ys,
                             input coord_type xe, input coord_type ye, input color_type col);
      int xa, ya, xb, yb, dx, dy, adx, ady, t;
      bit same, move, shallow;
      pixel_type pix;
      if (kind == KIND_START) begin
         xa = int'(xs);
         ya = int'(ys);
         xb = int'(xe);
         yb = int'(ye);
         dx = xb - xa;
         dy = yb - ya;
         adx = (dx < 0) ? -dx : dx;
         ady = (dy < 0) ? -dy : dy;
         same = (dx > 0 && dy > 0) || (dx < 0 && dy < 0);
         if (dx != 0 && ady <= adx && (dy == 0 || same)) ln_oct = OCT_SHALLOW_UP;
         else if (ady > adx && ((dx == 0) ? (dy > 0) : same)) ln_oct = OCT_STEEP_UP;
         else if (dx != 0 && ady <= adx) ln_oct = OCT_SHALLOW_DOWN;
         else ln_oct = OCT_STEEP_DOWN;
         shallow = (ln_oct == OCT_SHALLOW_UP) || (ln_oct == OCT_SHALLOW_DOWN);
         if (shallow ? (xa > xb) : (ya > yb)) begin
            t = xa; xa = xb; xb = t;
            t = ya; ya = yb; yb = t;
         end
         dx = xb - xa;
         dy = yb - ya;
         case (ln_oct)
            OCT_SHALLOW_UP: begin
               ln_dec = dx - 2 * dy;
               ln_keep = -2 * dy;
               ln_move = 2 * dx - 2 * dy;
               ln_end = xb;
            end
            OCT_STEEP_UP: begin
               ln_dec = 2 * dx - dy;
               ln_keep = 2 * dx;
               ln_move = 2 * dx - 2 * dy;
               ln_end = yb;
            end
            OCT_SHALLOW_DOWN: begin
               ln_dec = -dx - 2 * dy;
               ln_keep = -2 * dy;
               ln_move = -2 * dx - 2 * dy;
               ln_end = xb;
            end
            default: begin
               ln_dec = 2 * dx + dy;
               ln_keep = 2 * dx;
               ln_move = 2 * dx + 2 * dy;
               ln_end = yb;
            end
         endcase
         ln_x = xa;
         ln_y = ya;
         ln_color = col;
         line_on = 1'b1;
      end else begin
         if (!line_on) return;
         case (ln_oct)
            OCT_SHALLOW_UP: begin
               move = (ln_dec <= 0);
               if (move) ln_y++;
               ln_x++;
            end
            OCT_STEEP_UP: begin
               move = (ln_dec >= 0);
               if (move) ln_x++;
               ln_y++;
            end
            OCT_SHALLOW_DOWN: begin
               move = (ln_dec >= 0);
               if (move) ln_y--;
               ln_x++;
            end
            default: begin
               move = (ln_dec <= 0);
               if (move) ln_x--;
               ln_y++;
            end
         endcase
         ln_dec += move ? ln_move : ln_keep;
      end
      shallow = (ln_oct == OCT_SHALLOW_UP) || (ln_oct == OCT_SHALLOW_DOWN);
      pix.last = ((shallow ? ln_x : ln_y) == ln_end);
      if (pix.last) line_on = 1'b0;
      pix.px = coord_type'(ln_x);
      pix.py = coord_type'(ln_y);
      pix.col = ln_color;
      pixel_q.push_back(pix);
   endtask

   task automatic push_cmd(input logic kind, input coord_type xs, input coord_type ys,
                           input coord_type xe, input coord_type ye, input color_type col,
                           input bit drain);
      cmd_type c;
      c.kind = kind;
      c.xs = xs;
      c.ys = ys;
      c.xe = xe;
      c.ye = ye;
      c.col = col;
      c.drain = drain;
      cmd_q.push_back(c);
   endtask

   // The step items carry random data that the block must not use.
   task automatic add_line(input coord_type xs, input coord_type ys, input coord_type xe,
                           input coord_type ye, input color_type col, input int steps,
                           input bit drain);
      push_cmd(KIND_START, xs, ys, xe, ye, col, drain);
      repeat (steps) begin
         push_cmd(KIND_STEP, coord_type'($urandom), coord_type'($urandom),
                  coord_type'($urandom), coord_type'($urandom), color_type'($urandom),
                  1'b0);
      end
   endtask

   always @(posedge clock) begin
      cmd_type nxt;
      logic [REQ_DATA_BITS-1:0] word;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (cmd_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (cmd_q[0].drain && (req_tvalid || !drained_q)) begin
            req_tvalid <= 1'b0;
         end else begin
            nxt = cmd_q.pop_front();
            word = '0;
            word[REQ_FIELD_BITS-1:0] = {nxt.col, nxt.ye, nxt.xe, nxt.ys, nxt.xs};
            req_tdata <= word;
            req_tuser <= nxt.kind;
            req_tvalid <= 1'b1;
            send_gap = idle_len(tx_calm);
         end
      end
   end

   // Besides random stalls, one long hold-off lets the block back up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle == HOLD_AT) rx_stall = HOLD_LEN;
         else if (rx_stall == 0 && $urandom_range(0, 3) == 0) rx_stall = idle_len(rx_calm);
         if (rx_stall > 0) begin
            rsp_tready <= 1'b0;
            rx_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      pixel_type got;
      pixel_type want;
      if (reset) begin
         drained_q <= 1'b1;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.px = rsp_tdata[COORD_BITS-1:0];
            got.py = rsp_tdata[2*COORD_BITS-1:COORD_BITS];
            got.col = rsp_tdata[RSP_FIELD_BITS-1:2*COORD_BITS];
            got.last = rsp_tlast;
            if (pixel_q.size() == 0) begin
               $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d color=%h last=%b",
                        $time, got.px, got.py, got.col, got.last);
               err_count++;
            end else begin
               want = pixel_q.pop_front();
               if (got.px !== want.px) begin
                  $display("%0t: pixel_x expected %0d actual %0d", $time, want.px, got.px);
                  err_count++;
               end
               if (got.py !== want.py) begin
                  $display("%0t: pixel_y expected %0d actual %0d", $time, want.py, got.py);
                  err_count++;
               end
               if (got.col !== want.col) begin
                  $display("%0t: pixel_color expected %h actual %h", $time, want.col, got.col);
                  err_count++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                  err_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            next_pixel(req_tuser, req_tdata[COORD_BITS-1:0],
                       req_tdata[2*COORD_BITS-1:COORD_BITS],
                       req_tdata[3*COORD_BITS-1:2*COORD_BITS],
                       req_tdata[4*COORD_BITS-1:3*COORD_BITS],
                       req_tdata[REQ_FIELD_BITS-1:4*COORD_BITS]);
         end
         drained_q <= (pixel_q.size() == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int fed;
      int last_drain;
      int r;
      int span;
      int len;
      int steps;
      int ddx;
      int ddy;
      bit drain;
      coord_type xs, ys, xe, ye;

      // Directed lines: a stray step, a single point, both axis-parallel cases, each slope
      // case with a tie on its first step, and a new start that drops a long line.
      push_cmd(KIND_STEP, '1, '1, '1, '1, '1, 1'b0);
      add_line(coord_type'(0), coord_type'(0), coord_type'(0), coord_type'(0),
               24'h000000, 1, 1'b0);
      add_line(coord_type'(COORD_MAX), coord_type'(COORD_MAX), coord_type'(COORD_MAX - 2),
               coord_type'(COORD_MAX), 24'hFFFFFF, 3, 1'b0);
      add_line(coord_type'(0), coord_type'(COORD_MAX - 2), coord_type'(0),
               coord_type'(COORD_MAX), 24'h00FF00, 2, 1'b0);
      add_line(coord_type'(COORD_MAX), coord_type'(2), coord_type'(COORD_MAX),
               coord_type'(0), 24'hFF0000, 2, 1'b0);
      add_line(coord_type'(10), coord_type'(10), coord_type'(12), coord_type'(11),
               24'h123456, 2, 1'b0);
      add_line(coord_type'(20), coord_type'(20), coord_type'(21), coord_type'(22),
               24'hABCDEF, 2, 1'b0);
      add_line(coord_type'(30), coord_type'(31), coord_type'(32), coord_type'(30),
               24'h555555, 2, 1'b0);
      add_line(coord_type'(40), coord_type'(40), coord_type'(41), coord_type'(38),
               24'hAAAAAA, 2, 1'b0);
      add_line(coord_type'(0), coord_type'(0), coord_type'(COORD_MAX), coord_type'(1000),
               24'h0F0F0F, 1, 1'b0);

      fed = 0;
      last_drain = 0;
      while (fed < LINE_ITEMS) begin
         drain = (fed == 0) || (fed - last_drain > 90);
         if (drain) last_drain = fed;
         r = $urandom_range(0, 99);
         if (r < 70) begin
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
            xs = coord_type'($urandom);
            ys = coord_type'($urandom);
            xe = near(xs, span);
            ye = near(ys, span);
            if ($urandom_range(0, 7) == 0) xe = xs;
            else if ($urandom_range(0, 7) == 0) ye = ys;
            ddx = int'(xe) - int'(xs);
            ddy = int'(ye) - int'(ys);
            if (ddx < 0) ddx = -ddx;
            if (ddy < 0) ddy = -ddy;
            len = (ddx > ddy) ? ddx : ddy;
            if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, len);
            else steps = len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
            add_line(xs, ys, xe, ye, color_type'($urandom), steps, drain);
            fed += 1 + ((steps < len) ? steps : len);
         end else if (r < 85) begin
            steps = $urandom_range(0, 4);
            add_line(coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
                     coord_type'($urandom), color_type'($urandom), steps, drain);
            fed += 1 + steps;
         end else begin
            push_cmd(1'($urandom_range(0, 1)), coord_type'($urandom), coord_type'($urandom),
                     coord_type'($urandom), coord_type'($urandom), color_type'($urandom),
                     drain);
            fed++;
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (cmd_q.size() != 0 || req_tvalid || !drained_q || pixel_q.size() != 0);
      repeat (8) @(posedge clock);

      if (err_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
